// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_AT(label, clk, rst_n, !(cond), msg)

`endif

// ----- rtl/core/bcr_pkg.sv -----
`timescale 1ns / 1ps

package bcr_pkg;

	localparam int DEF_MAX_COLS   = 40;
	localparam int DEF_MAX_ROWS   = 8;
	localparam int CMD_FIFO_DEPTH = 2;

	localparam int LIM_W     = 7;
	localparam int LEN_W     = 10;
	localparam int RES_W     = 5;
	localparam int ROW_W     = 3;
	localparam int WROW_W    = 4;
	localparam int COL_W     = 6;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		DIR_LEFT  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_UP    = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLS   = 2'd0,
		REG_ROWS   = 2'd1,
		REG_CELL_W = 2'd2,
		REG_CELL_H = 2'd3
	} reg_idx_t;

	typedef struct packed {
		dir_t             dir;
		logic             horiz;
		logic             rev;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] lvl_a;
		logic [LEN_W-1:0] lvl_b;
		logic [RES_W-1:0] res;
		logic [LIM_W-1:0] limit;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic step;
	} walk_status_t;

endpackage

// ----- rtl/core/bcr_front.sv -----
`timescale 1ns / 1ps

module bcr_front import bcr_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic             push,
	output logic             full,
	input  logic [1:0]       direction,
	input  logic [ROW_W-1:0] start_row,
	input  logic [COL_W-1:0] start_col,
	input  logic [LEN_W-1:0] full_length,
	input  logic [LEN_W-1:0] level_a,
	input  logic [LEN_W-1:0] level_b,
	input  logic [5:0]       cols_in_use,
	input  logic [3:0]       rows_in_use,
	input  logic [3:0]       cell_width,
	input  logic [4:0]       cell_height,
	input  logic             q_full,
	output logic             q_wr,
	output cmd_t             q_data
);

	logic [LIM_W-1:0] cols_lim;
	logic [LIM_W-1:0] rows_lim;
	logic [LIM_W-1:0] start_pos;
	logic             fixed_off;
	logic             drop;
	dir_t             dir;

	function automatic logic [LEN_W-1:0] clamp_level(
		input logic [LEN_W-1:0] lvl,
		input logic [LEN_W-1:0] len,
		input logic             rev
	);
		logic [LEN_W-1:0] lc;
		if (lvl == '0) begin
			lc = LEN_W'(1);
		end else if (lvl > len) begin
			lc = len;
		end else begin
			lc = lvl;
		end
		return rev ? len - lc : lc;
	endfunction

	always_comb begin
		dir = dir_t'(direction);
		cols_lim = ({1'b0, cols_in_use} > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS)
			: {1'b0, cols_in_use};
		rows_lim = ({3'b0, rows_in_use} > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
			: {3'b0, rows_in_use};

		q_data.dir   = dir;
		q_data.horiz = (dir == DIR_LEFT) || (dir == DIR_RIGHT);
		q_data.rev   = (dir == DIR_LEFT) || (dir == DIR_UP);
		q_data.row   = start_row;
		q_data.col   = start_col;
		q_data.len   = full_length;
		q_data.lvl_a = clamp_level(level_a, full_length, q_data.rev);
		q_data.lvl_b = clamp_level(level_b, full_length, q_data.rev);
		q_data.res   = q_data.horiz ? {1'b0, cell_width} : cell_height;
		q_data.limit = q_data.horiz ? cols_lim : rows_lim;

		start_pos = q_data.horiz ? {1'b0, start_col} : {4'b0, start_row};
		fixed_off = q_data.horiz ? ({4'b0, start_row} >= rows_lim)
			: ({1'b0, start_col} >= cols_lim);
		// commands that write no cell end here
		drop = (full_length == '0) || fixed_off || (start_pos >= q_data.limit);

		full = q_full;
		q_wr = push && !q_full && !drop;
	end

endmodule

// ----- rtl/core/bcr_cmd_fifo.sv -----
`timescale 1ns / 1ps

module bcr_cmd_fifo import bcr_pkg::*; #(
	parameter int DEPTH = CMD_FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd,
	output logic rd_valid,
	output cmd_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr && !full;
	assign do_rd    = rd && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- rtl/core/bcr_walker.sv -----
`timescale 1ns / 1ps

module bcr_walker import bcr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic             empty,
	input  logic             pop,
	output logic [ROW_W-1:0] cell_row,
	output logic [COL_W-1:0] cell_col,
	output logic [1:0]       cell_direction,
	output logic [RES_W-1:0] fill_a,
	output logic [RES_W-1:0] fill_b,
	output logic             last_cell,
	output walk_status_t     status
);

	logic              busy_q;
	dir_t              dir_q;
	logic              horiz_q;
	logic              rev_q;
	logic [RES_W-1:0]  res_q;
	logic [LIM_W-1:0]  limit_q;
	logic [WROW_W-1:0] row_q;
	logic [COL_W-1:0]  col_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W-1:0]  la_q;
	logic [LEN_W-1:0]  lb_q;

	logic              out_valid_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	dir_t              out_dir_q;
	logic [RES_W-1:0]  out_fa_q;
	logic [RES_W-1:0]  out_fb_q;
	logic              out_last_q;

	logic                   advance;
	logic                   load;
	logic                   step;
	logic                   last;
	logic [LIM_W-1:0]       pos_nxt;
	logic [LEN_W+RES_W-1:0] take_a;
	logic [LEN_W+RES_W-1:0] take_b;

	// returns {level left, fill of this cell}
	function automatic logic [LEN_W+RES_W-1:0] take_fill(
		input logic [LEN_W-1:0] lvl,
		input logic [RES_W-1:0] res,
		input logic             rev
	);
		logic [LEN_W-1:0] left;
		logic [RES_W-1:0] fill;
		if (lvl >= LEN_W'(res)) begin
			left = lvl - LEN_W'(res);
			fill = rev ? '0 : res;
		end else begin
			left = '0;
			fill = rev ? res - lvl[RES_W-1:0] : lvl[RES_W-1:0];
		end
		return {left, fill};
	endfunction

	always_comb begin
		advance = !out_valid_q || pop;
		load    = !busy_q && cmd_valid;
		step    = busy_q && advance;
		cmd_pop = load;
		take_a  = take_fill(la_q, res_q, rev_q);
		take_b  = take_fill(lb_q, res_q, rev_q);
		pos_nxt = horiz_q ? {1'b0, col_q} + LIM_W'(1) : {3'b0, row_q} + LIM_W'(1);
		last    = (rem_q <= LEN_W'(res_q)) || (pos_nxt >= limit_q);
		status.busy = busy_q;
		status.step = step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (step && last) begin
				busy_q <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (advance) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dir_q   <= cmd.dir;
			horiz_q <= cmd.horiz;
			rev_q   <= cmd.rev;
			res_q   <= cmd.res;
			limit_q <= cmd.limit;
			row_q   <= {1'b0, cmd.row};
			col_q   <= cmd.col;
			rem_q   <= cmd.len;
			la_q    <= cmd.lvl_a;
			lb_q    <= cmd.lvl_b;
		end else if (step) begin
			la_q  <= take_a[LEN_W+RES_W-1:RES_W];
			lb_q  <= take_b[LEN_W+RES_W-1:RES_W];
			rem_q <= rem_q - LEN_W'(res_q);
			if (horiz_q) begin
				col_q <= col_q + COL_W'(1);
			end else begin
				row_q <= row_q + WROW_W'(1);
			end
		end
		if (step) begin
			out_row_q  <= row_q[ROW_W-1:0];
			out_col_q  <= col_q;
			out_dir_q  <= dir_q;
			out_fa_q   <= take_a[RES_W-1:0];
			out_fb_q   <= take_b[RES_W-1:0];
			out_last_q <= last;
		end
	end

	assign empty          = !out_valid_q;
	assign cell_row       = out_row_q;
	assign cell_col       = out_col_q;
	assign cell_direction = out_dir_q;
	assign fill_a         = out_fa_q;
	assign fill_b         = out_fb_q;
	assign last_cell      = out_last_q;

endmodule

// ----- rtl/core/bar_to_cell_rasterizer.sv -----
`timescale 1ns / 1ps

// channel   signals                      direction  width
// command   push, full, 6 fields         in         2/3/6/10/10/10
// cell      empty, pop, 6 fields         out        3/6/2/5/5/1
// config    cfg_we, cfg_index, cfg_data  in         1/2/6
//
// a command is checked in the cycle it is pushed and waits in a two-entry queue
// the walker takes a queued command when idle, then writes one cell per cycle while
// the output is free, and takes no new command until its last cell is written
// pop low holds the output register and the walker; the queue fills to two items
// arst_n clears the queue, the walker and the output; registers return to 20/4/5/8

module bar_to_cell_rasterizer import bcr_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           direction,
	input  logic [ROW_W-1:0]     start_row,
	input  logic [COL_W-1:0]     start_col,
	input  logic [LEN_W-1:0]     full_length,
	input  logic [LEN_W-1:0]     level_a,
	input  logic [LEN_W-1:0]     level_b,
	output logic                 empty,
	input  logic                 pop,
	output logic [ROW_W-1:0]     cell_row,
	output logic [COL_W-1:0]     cell_col,
	output logic [1:0]           cell_direction,
	output logic [RES_W-1:0]     fill_a,
	output logic [RES_W-1:0]     fill_b,
	output logic                 last_cell,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

`include "assert_macros.svh"

	logic [5:0]   cols_in_use_q;
	logic [3:0]   rows_in_use_q;
	logic [3:0]   cell_width_q;
	logic [4:0]   cell_height_q;

	logic         q_wr;
	logic         q_full;
	cmd_t         q_wr_data;
	logic         q_rd;
	logic         q_valid;
	cmd_t         q_rd_data;
	walk_status_t walk_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_in_use_q <= 6'd20;
			rows_in_use_q <= 4'd4;
			cell_width_q  <= 4'd5;
			cell_height_q <= 5'd8;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_COLS:   cols_in_use_q <= cfg_data[5:0];
				REG_ROWS:   rows_in_use_q <= cfg_data[3:0];
				REG_CELL_W: cell_width_q  <= cfg_data[3:0];
				REG_CELL_H: cell_height_q <= cfg_data[4:0];
			endcase
		end
	end

	bcr_front #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.push        (push),
		.full        (full),
		.direction   (direction),
		.start_row   (start_row),
		.start_col   (start_col),
		.full_length (full_length),
		.level_a     (level_a),
		.level_b     (level_b),
		.cols_in_use (cols_in_use_q),
		.rows_in_use (rows_in_use_q),
		.cell_width  (cell_width_q),
		.cell_height (cell_height_q),
		.q_full      (q_full),
		.q_wr        (q_wr),
		.q_data      (q_wr_data)
	);

	bcr_cmd_fifo #(
		.DEPTH (CMD_FIFO_DEPTH)
	) u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_data  (q_wr_data),
		.full     (q_full),
		.rd       (q_rd),
		.rd_valid (q_valid),
		.rd_data  (q_rd_data)
	);

	bcr_walker u_walker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (q_valid),
		.cmd            (q_rd_data),
		.cmd_pop        (q_rd),
		.empty          (empty),
		.pop            (pop),
		.cell_row       (cell_row),
		.cell_col       (cell_col),
		.cell_direction (cell_direction),
		.fill_a         (fill_a),
		.fill_b         (fill_b),
		.last_cell      (last_cell),
		.status         (walk_status)
	);

	`ASSERT_NEVER(a_no_write_when_full, clk, arst_n, q_wr && q_full, "command written into full queue")
	`ASSERT_AT(a_idle_walker_loads, clk, arst_n, (!walk_status.busy && q_valid) |=> walk_status.busy, "idle walker left a queued command")
	`ASSERT_AT(a_step_gives_cell, clk, arst_n, walk_status.step |=> !empty, "walker step produced no cell")
	`ASSERT_NEVER(a_pop_only_when_idle, clk, arst_n, q_rd && walk_status.busy, "queue popped while walking")

endmodule
